### src/fcq_pkg.sv
// Shared types and codes for the free-chunk quarantine ring.
// Used by fcq_cell and the top level free_chunk_quarantine_ring_core.
package fcq_pkg;

   localparam int DATA_W = 32;

   // Request action codes.
   localparam logic [1:0] ACT_ADD      = 2'd0;
   localparam logic [1:0] ACT_CONTAINS = 2'd1;
   localparam logic [1:0] ACT_FLUSH    = 2'd2;

   // Result kind codes.
   localparam logic [1:0] KIND_RELEASE  = 2'd0;
   localparam logic [1:0] KIND_ADD      = 2'd1;
   localparam logic [1:0] KIND_CONTAINS = 2'd2;
   localparam logic [1:0] KIND_FLUSH    = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_MAX_CHUNK = 1'b0;
   localparam logic CSR_BUDGET    = 1'b1;

   localparam logic [DATA_W-1:0] MAX_CHUNK_RESET = 32'd1024;
   localparam logic [DATA_W-1:0] BUDGET_RESET    = 32'd4096;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ADD   = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_HIT   = 5'b01000,
      ST_FLUSH = 5'b10000
   } state_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic shift;   // take the entry of the next younger cell
      logic load;    // take the chunk being enqueued
      logic valid;   // this cell holds a live entry
   } cell_ctrl_type;

endpackage

### src/fcq_cell.sv
// One slot of the quarantine chain: holds an address and a size, shifts
// towards the head on release and compares its address on a lookup.
// Depends on fcq_pkg.
module fcq_cell
   import fcq_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [DATA_W-1:0] next_addr,
   input  logic [DATA_W-1:0] next_size,
   input  logic [DATA_W-1:0] new_addr,
   input  logic [DATA_W-1:0] new_size,
   input  logic [DATA_W-1:0] query_addr,
   output logic [DATA_W-1:0] addr_out,
   output logic [DATA_W-1:0] size_out,
   output logic              match_out
);

   logic [DATA_W-1:0] addr_ff;
   logic [DATA_W-1:0] size_ff;
   logic              match_ff;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         addr_ff <= new_addr;
         size_ff <= new_size;
      end else if (ctrl.shift) begin
         addr_ff <= next_addr;
         size_ff <= next_size;
      end
      match_ff <= ctrl.valid && (addr_ff == query_addr);
   end

   assign addr_out  = addr_ff;
   assign size_out  = size_ff;
   assign match_out = match_ff;

endmodule

### src/free_chunk_quarantine_ring_core.sv
// Top level of the free-chunk quarantine ring: sequencer, byte accounting
// and the chain of fcq_cell slots. Depends on fcq_pkg and fcq_cell.
//
// Usage. A request beat is taken at a rising edge with start high and busy
// low; busy stays high until the last result of that request is on the rsp_
// ports, so the next request may be taken at the edge that accepts it.
// Results leave one per cycle on the rsp_ ports, each marked by rsp_valid
// for a single cycle, with rsp_last on the final beat of a request. The
// receiver cannot hold results off, so nothing here waits on it.
// The first result of an add or a flush is formed in ST_ADD or ST_FLUSH and
// registered on the rsp_ ports; a contains query passes ST_SCAN, the match
// register of every slot and ST_HIT first. An add gives one beat per evicted
// entry, then the answer; a contains query compares in every slot, then
// combines the hits; a flush gives one beat per held entry, then the total.
// The length of an add or a flush is set by the head of the chain, which
// releases one entry a cycle. Action code 3 is taken and ignored without any
// result. Configuration writes on csr_ apply at once and are to be made while
// idle; the user is bound to this, as the block itself leaves it unchecked.
// Reset empties the ring and restores the register defaults; no clearing
// pass is needed since only occupied slots are ever read.
module free_chunk_quarantine_ring_core
   import fcq_pkg::*;
#(
   parameter int SLOTS = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_action,
   input  logic [DATA_W-1:0] req_chunk_addr,
   input  logic [DATA_W-1:0] req_chunk_size,
   output logic              rsp_valid,
   output logic [1:0]        rsp_kind,
   output logic [DATA_W-1:0] rsp_out_addr,
   output logic [DATA_W-1:0] rsp_out_size,
   output logic              rsp_answer,
   output logic [DATA_W-1:0] rsp_released_bytes,
   output logic              rsp_last,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(SLOTS + 1);

   state_type         state_ff, state_in;
   logic [DATA_W-1:0] addr_ff, size_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [DATA_W-1:0] held_ff, held_in;
   logic [DATA_W-1:0] total_ff;
   logic [DATA_W-1:0] max_ff, budget_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [DATA_W-1:0] rsp_size_ff, rsp_size_in;
   logic              rsp_answer_ff, rsp_answer_in;
   logic [DATA_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              shift, load;
   logic              too_big, full, over_budget;
   logic [DATA_W:0]   sum_wide;

   logic [DATA_W-1:0] cell_addr  [SLOTS];
   logic [DATA_W-1:0] cell_size  [SLOTS];
   logic [SLOTS-1:0]  cell_match;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   assign too_big     = size_ff > max_ff;
   assign full        = count_ff >= CNT_W'(SLOTS);
   assign sum_wide    = {1'b0, held_ff} + {1'b0, size_ff};
   assign over_budget = sum_wide > {1'b0, budget_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      held_in       = held_ff;
      shift         = 1'b0;
      load          = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_kind_in   = KIND_RELEASE;
      rsp_addr_in   = '0;
      rsp_size_in   = '0;
      rsp_answer_in = 1'b0;
      rsp_bytes_in  = '0;
      rsp_last_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_ADD:      state_in = ST_ADD;
                  ACT_CONTAINS: state_in = ST_SCAN;
                  ACT_FLUSH:    state_in = ST_FLUSH;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_ADD: begin
            rsp_valid_in = 1'b1;
            if (too_big) begin
               rsp_kind_in = KIND_ADD;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end else if (full || over_budget) begin
               if (count_ff == '0) begin
                  // The chunk alone exceeds the budget: refused.
                  rsp_kind_in = KIND_ADD;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_addr_in = cell_addr[0];
                  rsp_size_in = cell_size[0];
                  shift       = 1'b1;
                  count_in    = count_ff - 1'b1;
                  held_in     = held_ff - cell_size[0];
               end
            end else begin
               load          = 1'b1;
               count_in      = count_ff + 1'b1;
               held_in       = sum_wide[DATA_W-1:0];
               rsp_kind_in   = KIND_ADD;
               rsp_answer_in = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_SCAN: begin
            state_in = ST_HIT;
         end
         ST_HIT: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_CONTAINS;
            rsp_answer_in = |cell_match;
            rsp_last_in   = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_FLUSH: begin
            rsp_valid_in = 1'b1;
            if (count_ff != '0) begin
               rsp_addr_in = cell_addr[0];
               rsp_size_in = cell_size[0];
               shift       = 1'b1;
               count_in    = count_ff - 1'b1;
               held_in     = held_ff - cell_size[0];
            end else begin
               rsp_kind_in  = KIND_FLUSH;
               rsp_bytes_in = total_ff;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= MAX_CHUNK_RESET;
         budget_ff    <= BUDGET_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_MAX_CHUNK: max_ff    <= csr_wdata;
               CSR_BUDGET:    budget_ff <= csr_wdata;
               default:       max_ff    <= max_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff  <= req_chunk_addr;
         size_ff  <= req_chunk_size;
         total_ff <= held_ff;
      end
      rsp_kind_ff   <= rsp_kind_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_size_ff   <= rsp_size_in;
      rsp_answer_ff <= rsp_answer_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Slot 0 is always the oldest entry; a release moves every slot one place
   // towards the head and an enqueue writes the first free slot.
   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [DATA_W-1:0] next_addr, next_size;

      assign ctrl = '{shift: shift,
                      load:  load && (count_ff == CNT_W'(i)),
                      valid: CNT_W'(i) < count_ff};

      if (i == SLOTS - 1) begin : g_tail
         assign next_addr = addr_ff;
         assign next_size = size_ff;
      end else begin : g_link
         assign next_addr = cell_addr[i+1];
         assign next_size = cell_size[i+1];
      end

      fcq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .next_addr  (next_addr),
         .next_size  (next_size),
         .new_addr   (addr_ff),
         .new_size   (size_ff),
         .query_addr (addr_ff),
         .addr_out   (cell_addr[i]),
         .size_out   (cell_size[i]),
         .match_out  (cell_match[i])
      );
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_out_addr       = rsp_addr_ff;
   assign rsp_out_size       = rsp_size_ff;
   assign rsp_answer         = rsp_answer_ff;
   assign rsp_released_bytes = rsp_bytes_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("entry count exceeds the number of slots");

   a_empty_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (held_ff == '0))
      else $error("bytes held with an empty ring");

   a_release_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_RELEASE) |-> !rsp_last)
      else $error("released chunk beat marked as last");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> !busy)
      else $error("still busy when the last beat is out");

   a_shift_load: assert property (@(posedge clock) disable iff (reset)
      !(shift && load))
      else $error("enqueue and release in the same cycle");
`endif

endmodule

### test/free_chunk_quarantine_ring_core_tb.sv
// Self-checking testbench for free_chunk_quarantine_ring_core: directed and random add, contains
// and flush requests under several register settings, checked beat by beat against a predictor.
// Depends on fcq_pkg and the ring RTL only.
module free_chunk_quarantine_ring_core_tb;
   import fcq_pkg::*;

   localparam int SLOT_COUNT  = 16;
   localparam int PHASE_ITEMS = 15;
   localparam int CYCLE_LIMIT = 100000;
   localparam logic [1:0] ACT_NONE = 2'd3;

   typedef struct packed {
      logic [1:0]        action;
      logic [DATA_W-1:0] addr;
      logic [DATA_W-1:0] size;
   } chunk_request_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] out_addr;
      logic [DATA_W-1:0] out_size;
      logic              answer;
      logic [DATA_W-1:0] released_bytes;
      logic              last;
   } ring_result_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic [1:0]        req_action;
   logic [DATA_W-1:0] req_chunk_addr;
   logic [DATA_W-1:0] req_chunk_size;
   logic              rsp_valid;
   logic [1:0]        rsp_kind;
   logic [DATA_W-1:0] rsp_out_addr;
   logic [DATA_W-1:0] rsp_out_size;
   logic              rsp_answer;
   logic [DATA_W-1:0] rsp_released_bytes;
   logic              rsp_last;
   logic              csr_we;
   logic              csr_index;
   logic [DATA_W-1:0] csr_wdata;

   // Predicted contents of the ring.
   logic [DATA_W-1:0] q_addr [SLOT_COUNT];
   logic [DATA_W-1:0] q_size [SLOT_COUNT];
   int                q_oldest;
   int                q_count;
   logic [DATA_W-1:0] q_bytes;
   logic [DATA_W-1:0] q_max_chunk;
   logic [DATA_W-1:0] q_budget;

   chunk_request_type free_requests [$];
   ring_result_type   expected_ring_out [$];
   logic [DATA_W-1:0] known_addrs [$];
   logic              beat_taken;
   int                send_idle_pct;
   int                flush_pct;
   int                mismatch_count;
   int                cycle_count;

   free_chunk_quarantine_ring_core #(.SLOTS(SLOT_COUNT)) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_chunk_addr     (req_chunk_addr),
      .req_chunk_size     (req_chunk_size),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_out_addr       (rsp_out_addr),
      .rsp_out_size       (rsp_out_size),
      .rsp_answer         (rsp_answer),
      .rsp_released_bytes (rsp_released_bytes),
      .rsp_last           (rsp_last),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void push_expected(input logic [1:0] kind, input logic [DATA_W-1:0] addr,
                                         input logic [DATA_W-1:0] size, input logic answer,
                                         input logic [DATA_W-1:0] total, input logic last);
      ring_result_type r;
      r.kind           = kind;
      r.out_addr       = addr;
      r.out_size       = size;
      r.answer         = answer;
      r.released_bytes = total;
      r.last           = last;
      expected_ring_out.push_back(r);
   endfunction

   function automatic void release_oldest_chunk();
      push_expected(KIND_RELEASE, q_addr[q_oldest], q_size[q_oldest], 1'b0, '0, 1'b0);
      q_bytes  = q_bytes - q_size[q_oldest];
      q_oldest = (q_oldest + 1) % SLOT_COUNT;
      q_count--;
   endfunction

   function automatic void predict_quarantine(input chunk_request_type r);
      logic              taken;
      logic              found;
      logic [DATA_W-1:0] total;
      int                slot;
      case (r.action)
         ACT_ADD: begin
            taken = 1'b0;
            if (r.size <= q_max_chunk) begin
               taken = 1'b1;
               // The comparison is one bit wider so that the sum cannot wrap.
               while (q_count >= SLOT_COUNT ||
                      {1'b0, q_bytes} + {1'b0, r.size} > {1'b0, q_budget}) begin
                  if (q_count == 0) begin
                     taken = 1'b0;
                     break;
                  end
                  release_oldest_chunk();
               end
               if (taken) begin
                  slot = (q_oldest + q_count) % SLOT_COUNT;
                  q_addr[slot] = r.addr;
                  q_size[slot] = r.size;
                  q_count++;
                  q_bytes = q_bytes + r.size;
               end
            end
            push_expected(KIND_ADD, '0, '0, taken, '0, 1'b1);
         end
         ACT_CONTAINS: begin
            found = 1'b0;
            for (int i = 0; i < q_count; i++)
               if (q_addr[(q_oldest + i) % SLOT_COUNT] == r.addr) found = 1'b1;
            push_expected(KIND_CONTAINS, '0, '0, found, '0, 1'b1);
         end
         ACT_FLUSH: begin
            total = q_bytes;
            while (q_count > 0) release_oldest_chunk();
            push_expected(KIND_FLUSH, '0, '0, 1'b0, total, 1'b1);
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input ring_result_type want,
                                  input ring_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected kind %0d addr %h size %h answer %0d total %h last %0d",
                  $realtime, what, want.kind, want.out_addr, want.out_size, want.answer,
                  want.released_bytes, want.last);
         $display("   got kind %0d addr %h size %h answer %0d total %h last %0d",
                  got.kind, got.out_addr, got.out_size, got.answer,
                  got.released_bytes, got.last);
      end
   endtask

   // Checks result beats first, then predicts for a request beat taken at this edge.
   always @(posedge clock) begin
      ring_result_type   got;
      ring_result_type   want;
      chunk_request_type req;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         beat_taken <= start && !busy;
         if (rsp_valid) begin
            got = {rsp_kind, rsp_out_addr, rsp_out_size, rsp_answer, rsp_released_bytes,
                   rsp_last};
            if (expected_ring_out.size() == 0) begin
               report_mismatch("unexpected result beat", '0, got);
            end else begin
               want = expected_ring_out.pop_front();
               if (got.kind !== want.kind || got.out_addr !== want.out_addr ||
                   got.out_size !== want.out_size || got.answer !== want.answer ||
                   got.released_bytes !== want.released_bytes || got.last !== want.last)
                  report_mismatch("result mismatch", want, got);
            end
         end
         if (start && !busy) begin
            req = {req_action, req_chunk_addr, req_chunk_size};
            predict_quarantine(req);
         end
      end
   end

   // Request driver: a new beat is offered once the previous one has been taken.
   always @(negedge clock) begin
      chunk_request_type next;
      if (!start || beat_taken) begin
         if (!reset && free_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next = free_requests.pop_front();
            start          <= 1'b1;
            req_action     <= next.action;
            req_chunk_addr <= next.addr;
            req_chunk_size <= next.size;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic void remember_addr(input logic [DATA_W-1:0] addr);
      known_addrs.push_back(addr);
      if (known_addrs.size() > SLOT_COUNT) void'(known_addrs.pop_front());
   endfunction

   task automatic queue_request(input logic [1:0] action, input logic [DATA_W-1:0] addr,
                                input logic [DATA_W-1:0] size);
      if (action == ACT_ADD) remember_addr(addr);
      free_requests.push_back({action, addr, size});
   endtask

   // Sizes lean towards values that fit a few times into the budget, with the chunk
   // limit and just above it well represented; addresses often repeat recently added ones.
   function automatic chunk_request_type random_request();
      chunk_request_type r;
      int                pick;
      logic [DATA_W-1:0] span;
      pick = $urandom_range(99);
      if (pick < 55) r.action = ACT_ADD;
      else if (pick < 95 - flush_pct) r.action = ACT_CONTAINS;
      else if (pick < 95) r.action = ACT_FLUSH;
      else r.action = ACT_NONE;
      if (known_addrs.size() != 0 && $urandom_range(99) < 50)
         r.addr = known_addrs[$urandom_range(known_addrs.size() - 1)];
      else
         r.addr = $urandom();
      span = q_budget >> 2;
      if (span > q_max_chunk) span = q_max_chunk;
      pick = $urandom_range(99);
      if (pick < 60) r.size = $urandom_range(span, 0);
      else if (pick < 75) r.size = q_max_chunk;
      else if (pick < 85) r.size = q_max_chunk + 1'b1;
      else r.size = $urandom();
      if (r.action == ACT_ADD) remember_addr(r.addr);
      return r;
   endfunction

   // Returns once every request has been taken and answered, plus time for an
   // ignored request that produces no beat to run out.
   task automatic wait_drained();
      do @(posedge clock);
      while (free_requests.size() != 0 || start || expected_ring_out.size() != 0);
      repeat (SLOT_COUNT + 4) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      if (index == CSR_MAX_CHUNK) q_max_chunk = value;
      else q_budget = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [DATA_W-1:0] max_chunk,
                            input logic [DATA_W-1:0] budget, input int idle_pct,
                            input int flushes, input int pause_at);
      int  counted;
      logic paused;
      chunk_request_type r;
      write_csr(CSR_MAX_CHUNK, max_chunk);
      write_csr(CSR_BUDGET, budget);
      send_idle_pct = idle_pct;
      flush_pct     = flushes;
      counted       = 0;
      paused        = 1'b0;
      while (counted < PHASE_ITEMS) begin
         if (counted == pause_at && !paused) begin
            wait_drained();
            paused = 1'b1;
         end
         r = random_request();
         free_requests.push_back(r);
         if (r.action != ACT_NONE) counted++;
      end
      wait_drained();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = ACT_ADD;
      req_chunk_addr = '0;
      req_chunk_size = '0;
      csr_we         = 1'b0;
      csr_index      = CSR_MAX_CHUNK;
      csr_wdata      = '0;
      beat_taken     = 1'b0;
      send_idle_pct  = 0;
      flush_pct      = 6;
      mismatch_count = 0;
      cycle_count    = 0;
      q_oldest       = 0;
      q_count        = 0;
      q_bytes        = '0;
      q_max_chunk    = MAX_CHUNK_RESET;
      q_budget       = BUDGET_RESET;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset register values.
      queue_request(ACT_CONTAINS, 32'h0000_0000, 32'h0);
      queue_request(ACT_FLUSH,    32'h0000_0000, 32'h0);
      queue_request(ACT_ADD,      32'h0000_0000, 32'd0);
      queue_request(ACT_ADD,      32'hFFFF_FFFF, 32'd1024);
      queue_request(ACT_ADD,      32'h1234_5678, 32'd1025);
      queue_request(ACT_ADD,      32'hA5A5_A5A5, 32'hFFFF_FFFF);
      queue_request(ACT_CONTAINS, 32'hFFFF_FFFF, 32'h0);
      queue_request(ACT_CONTAINS, 32'h0000_0000, 32'hFFFF_FFFF);
      queue_request(ACT_CONTAINS, 32'h1234_5678, 32'h0);
      queue_request(ACT_NONE,     32'hFFFF_FFFF, 32'hFFFF_FFFF);
      // The same address again, then enough bytes to force two evictions.
      queue_request(ACT_ADD,      32'h0000_0000, 32'd1000);
      queue_request(ACT_ADD,      32'h5A5A_5A5A, 32'd1024);
      queue_request(ACT_ADD,      32'h0000_0100, 32'd1024);
      queue_request(ACT_ADD,      32'h0000_0200, 32'd30);
      queue_request(ACT_CONTAINS, 32'h0000_0000, 32'h0);
      queue_request(ACT_FLUSH,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
      queue_request(ACT_ADD,      32'h0000_0300, 32'd1);
      queue_request(ACT_FLUSH,    32'h0000_0000, 32'h0);
      wait_drained();

      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,  6, -1);
      run_phase(32'h0000_0000, 32'h0000_0000, 53, 2, -1);
      run_phase(32'd300,       32'd1000,      37, 6, PHASE_ITEMS / 2);
      run_phase(32'd5000,      32'd2000,      0,  6, -1);
      // The budget drops to 100, below what the previous phase may have left held.
      run_phase(32'd4096,      32'd100,       53, 6, -1);
      run_phase(32'd64,        32'd100000,    37, 2, -1);

      if (mismatch_count == 0 && expected_ring_out.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

### filelist.f
src/fcq_pkg.sv
src/fcq_cell.sv
src/free_chunk_quarantine_ring_core.sv
test/free_chunk_quarantine_ring_core_tb.sv
